>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

>>> rtl/core/rlfg_pkg.sv
package rlfg_pkg;

   localparam int unsigned CfgW    = 12;
   localparam int unsigned PctW    = 7;
   localparam int unsigned RandW   = 15;
   localparam int unsigned FramesW = 13;
   localparam int unsigned IdxW    = 3;
   localparam int unsigned DvdW    = RandW;
   localparam int unsigned DvsW    = 13;
   localparam int unsigned StepW   = 4;
   localparam int unsigned ModSteps = DvdW;
   localparam int unsigned ReqW    = 48;
   localparam int unsigned RspW    = 8;

   // x mod 100 for a 15-bit x: quotient = (x * 5243) >> 19, exact below 2^15
   localparam int unsigned RecipW   = 13;
   localparam int unsigned QuoW     = 9;
   localparam int unsigned ProdW    = RandW + RecipW;
   localparam int unsigned PctShift = 19;

   localparam logic [RecipW-1:0] PctRecip     = RecipW'(5243);
   localparam logic [RandW-1:0]  PercentScale = RandW'(100);

   // phase codes
   localparam logic [1:0] PH_FLICKER = 2'd0;
   localparam logic [1:0] PH_ON      = 2'd1;
   localparam logic [1:0] PH_OFF     = 2'd2;

   // register indexes
   localparam logic [IdxW-1:0] CSR_FLICKER_AVG = 3'd0;
   localparam logic [IdxW-1:0] CSR_ON_AVG      = 3'd1;
   localparam logic [IdxW-1:0] CSR_OFF_AVG     = 3'd2;
   localparam logic [IdxW-1:0] CSR_BLINK_ON    = 3'd3;
   localparam logic [IdxW-1:0] CSR_BLINK_OFF   = 3'd4;
   localparam logic [IdxW-1:0] CSR_INVERT_PCT  = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHOICE,
      ST_JITTER,
      ST_BLINK,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MOP_CHOICE,
      MOP_JITTER,
      MOP_BLINK
   } mod_op_type;

   typedef struct packed {
      logic       load;
      logic       dec;
      logic       mod_start;
      mod_op_type op;
      logic       choose;
      logic       commit;
      logic       blink;
      logic       out_load;
   } rlfg_cmd_type;

   typedef struct packed {
      logic frames_zero;
      logic phase_flicker;
      logic next_flicker;
      logic mod_done;
      logic out_free;
   } rlfg_sts_type;

endpackage

>>> rtl/core/random_lamp_flicker_generator.sv
// Random lamp flicker generator.
// req_* carries one frame tick per item with three random numbers; rsp_*
// returns one item per tick with the lamp visibility and the phase after
// the tick's update. csr_* writes the six timing/percent registers; the
// user must write them only while idle, which the block does not enforce.
// Each tick runs up to two passes of a shared restoring remainder unit
// (15 steps a pass): the on/off choice when flicker expires, the duration
// jitter when any countdown expires, and the blink position during flicker.
// The percent draw for blink inversion uses a reciprocal multiply and adds
// no pass. rsp_tvalid rises when the sequencer leaves its done state, after
// the passes that the tick needs; the next item is taken once the sequencer
// is back in idle. One tick is in work at a time. The result sits in an
// output register, so the next tick is taken while a result waits; if
// rsp_tready stays low the sequencer holds the following result until the
// register frees up.
// Reset loads the default registers (20, 0, 40, 1, 1, 0), puts the lamp in
// flicker with an expired countdown and clears both channels.
`include "assert_macros.svh"

module random_lamp_flicker_generator
   import rlfg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [ReqW-1:0]    req_tdata,   // rand_choice, rand_jitter, rand_flip, pad
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RspW-1:0]    rsp_tdata,   // lamp_visible, lamp_phase[1:0], pad
   input  logic               csr_wen,
   input  logic [IdxW-1:0]    csr_addr,
   input  logic [CfgW-1:0]    csr_wdata
);

   rlfg_cmd_type cmd;
   rlfg_sts_type sts;
   logic         phase_known;

   rlfg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rlfg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign phase_known = (rsp_tdata[2:1] == PH_FLICKER) || (rsp_tdata[2:1] == PH_ON) ||
                        (rsp_tdata[2:1] == PH_OFF);

   `ASSERT_NEVER(a_phase_code, clock, reset, rsp_tvalid && !phase_known)
   `ASSERT_NEVER(a_off_dark, clock, reset, rsp_tvalid && rsp_tdata[2:1] == PH_OFF && rsp_tdata[0])
   `ASSERT_PROP(a_one_tick, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `ASSERT_PROP(a_mod_latency, clock, reset, cmd.mod_start |=> !sts.mod_done)

endmodule

>>> rtl/core/rlfg_mod.sv
// Restoring remainder unit, one dividend bit per cycle.
module rlfg_mod
   import rlfg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DvdW-1:0] dividend,
   input  logic [DvsW-1:0] divisor,
   output logic            done,
   output logic [DvsW-1:0] remainder
);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [StepW-1:0] count_ff, count_in;
   logic [DvdW-1:0]  dvd_ff, dvd_in;
   logic [DvsW-1:0]  dvs_ff, dvs_in;
   logic [DvsW-1:0]  rem_ff, rem_in;

   logic [DvsW:0]    trial;
   logic [DvsW:0]    diff;
   logic             fit;

   assign trial = {rem_ff, dvd_ff[DvdW-1]};
   assign fit   = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      if (start) begin
         active_in = 1'b1;
         count_in  = '0;
         dvd_in    = dividend;
         // zero divisor acts as one
         dvs_in    = (divisor == '0) ? DvsW'(1) : divisor;
         rem_in    = '0;
      end else if (active_ff) begin
         rem_in   = fit ? diff[DvsW-1:0] : trial[DvsW-1:0];
         dvd_in   = {dvd_ff[DvdW-2:0], 1'b0};
         count_in = count_ff + StepW'(1);
         if (count_ff == StepW'(ModSteps - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/core/rlfg_dp.sv
// Registers, phase/countdown state, remainder unit and result register.
module rlfg_dp
   import rlfg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [ReqW-1:0]    req_tdata,
   input  logic               csr_wen,
   input  logic [IdxW-1:0]    csr_addr,
   input  logic [CfgW-1:0]    csr_wdata,
   input  rlfg_cmd_type       cmd,
   output rlfg_sts_type       sts,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RspW-1:0]    rsp_tdata
);

   logic [CfgW-1:0]    flicker_avg_ff, on_avg_ff, off_avg_ff;
   logic [CfgW-1:0]    blink_on_ff, blink_off_ff;
   logic [PctW-1:0]    invert_pct_ff;

   logic [RandW-1:0]   choice_ff, jitter_ff, flip_ff;
   logic [1:0]         phase_ff, phase_in;
   logic [FramesW-1:0] frames_ff, frames_in;
   logic [1:0]         next_ff, next_in;
   logic [CfgW-1:0]    tm_ff, tm_in;
   logic               vis_ff, vis_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_vis_ff, rsp_vis_in;
   logic [1:0]         rsp_phase_ff, rsp_phase_in;

   logic [DvdW-1:0]    mod_dvd;
   logic [DvsW-1:0]    mod_dvs;
   logic               mod_done;
   logic [DvsW-1:0]    mod_rem;

   logic [DvsW-1:0]    onoff_sum;
   logic [DvsW-1:0]    period;
   logic [FramesW-1:0] t_sum;
   logic [FramesW-1:0] t_val;
   logic               vis_out;

   logic [QuoW-1:0]    flip_quo_ff;
   logic [ProdW-1:0]   flip_prod;
   logic [RandW-1:0]   flip_back;
   logic [RandW-1:0]   flip_rem;
   logic               flip_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         flicker_avg_ff <= CfgW'(20);
         on_avg_ff      <= CfgW'(0);
         off_avg_ff     <= CfgW'(40);
         blink_on_ff    <= CfgW'(1);
         blink_off_ff   <= CfgW'(1);
         invert_pct_ff  <= PctW'(0);
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_FLICKER_AVG: flicker_avg_ff <= csr_wdata;
            CSR_ON_AVG:      on_avg_ff      <= csr_wdata;
            CSR_OFF_AVG:     off_avg_ff     <= csr_wdata;
            CSR_BLINK_ON:    blink_on_ff    <= csr_wdata;
            CSR_BLINK_OFF:   blink_off_ff   <= csr_wdata;
            CSR_INVERT_PCT:  invert_pct_ff  <= csr_wdata[PctW-1:0];
            default: ;
         endcase
      end
   end

   assign onoff_sum = {1'b0, on_avg_ff} + {1'b0, off_avg_ff};
   assign period    = {1'b0, blink_on_ff} + {1'b0, blink_off_ff};

   always_comb begin
      case (cmd.op)
         MOP_CHOICE: begin
            mod_dvd = choice_ff;
            mod_dvs = onoff_sum;
         end
         MOP_JITTER: begin
            mod_dvd = jitter_ff;
            mod_dvs = {1'b0, tm_ff};
         end
         default: begin
            mod_dvd = {{(DvdW-FramesW){1'b0}}, frames_ff};
            mod_dvs = period;
         end
      endcase
   end

   rlfg_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mod_dvd),
      .divisor   (mod_dvs),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // percent draw: remainder by 100 via reciprocal multiply, quotient registered
   assign flip_prod = {{(ProdW-RandW){1'b0}}, flip_ff} * {{(ProdW-RecipW){1'b0}}, PctRecip};
   assign flip_back = {{(RandW-QuoW){1'b0}}, flip_quo_ff} * PercentScale;
   assign flip_rem  = flip_ff - flip_back;
   assign flip_hit  = flip_rem < {{(RandW-PctW){1'b0}}, invert_pct_ff};

   // average plus jitter minus half the average; remainder < tm keeps it in range
   assign t_sum = {1'b0, tm_ff} + mod_rem - {2'b00, tm_ff[CfgW-1:1]};
   assign t_val = (tm_ff == '0 || t_sum == '0) ? FramesW'(1) : t_sum;

   assign vis_out = (phase_ff == PH_FLICKER) ? vis_ff : (phase_ff != PH_OFF);

   always_comb begin
      phase_in     = phase_ff;
      frames_in    = frames_ff;
      next_in      = next_ff;
      tm_in        = tm_ff;
      vis_in       = vis_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_vis_in   = rsp_vis_ff;
      rsp_phase_in = rsp_phase_ff;
      if (cmd.load) begin
         // any expiring phase other than flicker goes back to flicker
         next_in = PH_FLICKER;
         tm_in   = flicker_avg_ff;
      end
      if (cmd.dec) begin
         frames_in = frames_ff - FramesW'(1);
      end
      if (cmd.choose) begin
         if (mod_rem < {1'b0, on_avg_ff}) begin
            next_in = PH_ON;
            tm_in   = on_avg_ff;
         end else begin
            next_in = PH_OFF;
            tm_in   = off_avg_ff;
         end
      end
      if (cmd.commit) begin
         phase_in  = next_ff;
         frames_in = t_val;
      end
      if (cmd.blink) begin
         vis_in = (mod_rem < {1'b0, blink_on_ff}) ^ flip_hit;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_vis_in   = vis_out;
         rsp_phase_in = phase_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FLICKER;
         frames_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         choice_ff <= req_tdata[RandW-1:0];
         jitter_ff <= req_tdata[2*RandW-1:RandW];
         flip_ff   <= req_tdata[3*RandW-1:2*RandW];
      end
      flip_quo_ff  <= flip_prod[PctShift +: QuoW];
      next_ff      <= next_in;
      tm_ff        <= tm_in;
      vis_ff       <= vis_in;
      rsp_vis_ff   <= rsp_vis_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign sts.frames_zero   = frames_ff == '0;
   assign sts.phase_flicker = phase_ff == PH_FLICKER;
   assign sts.next_flicker  = next_ff == PH_FLICKER;
   assign sts.mod_done      = mod_done;
   assign sts.out_free      = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspW-3){1'b0}}, rsp_phase_ff, rsp_vis_ff};

endmodule

>>> rtl/core/rlfg_ctrl.sv
// Sequencer: one tick at a time through choice, jitter and blink passes.
module rlfg_ctrl
   import rlfg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  rlfg_sts_type sts,
   output rlfg_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           entry_ff, entry_in;
   logic           accept;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign entry_in   = state_in != state_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (sts.frames_zero) begin
                  state_in = sts.phase_flicker ? ST_CHOICE : ST_JITTER;
               end else begin
                  state_in = sts.phase_flicker ? ST_BLINK : ST_DONE;
               end
            end
         end
         ST_CHOICE: if (sts.mod_done) state_in = ST_JITTER;
         ST_JITTER: begin
            if (sts.mod_done) state_in = sts.next_flicker ? ST_BLINK : ST_DONE;
         end
         ST_BLINK: if (sts.mod_done) state_in = ST_DONE;
         ST_DONE: if (sts.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.op = MOP_CHOICE;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            cmd.dec  = accept && !sts.frames_zero;
         end
         ST_CHOICE: begin
            cmd.op        = MOP_CHOICE;
            cmd.mod_start = entry_ff;
            cmd.choose    = sts.mod_done;
         end
         ST_JITTER: begin
            cmd.op        = MOP_JITTER;
            cmd.mod_start = entry_ff;
            cmd.commit    = sts.mod_done;
         end
         ST_BLINK: begin
            cmd.op        = MOP_BLINK;
            cmd.mod_start = entry_ff;
            cmd.blink     = sts.mod_done;
         end
         ST_DONE: cmd.out_load = sts.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         entry_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         entry_ff <= entry_in;
      end
   end

endmodule

>>> dv/tb_random_lamp_flicker_generator.sv
`timescale 1ns / 1ps

module tb_random_lamp_flicker_generator;
   import rlfg_pkg::*;

   localparam logic [IdxW-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [IdxW-1:0] CSR_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic          vis;
      logic [1:0]    ph;
   } lamp_out_type;

   // one row of the directed table: either a register write or a tick
   typedef struct packed {
      logic             wr;
      logic [IdxW-1:0]  idx;
      logic [CfgW-1:0]  val;
      logic [14:0]      ch;
      logic [14:0]      jt;
      logic [14:0]      fl;
      logic             typed;
      logic             vis;
      logic [1:0]       ph;
   } stim_row_type;

   localparam int NumRows = 38;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [ReqW-1:0]    req_tdata = '0;   // rand_choice, rand_jitter, rand_flip, pad
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RspW-1:0]    rsp_tdata;        // lamp_visible, lamp_phase[1:0], pad
   logic               csr_wen = 1'b0;
   logic [IdxW-1:0]    csr_addr = '0;
   logic [CfgW-1:0]    csr_wdata = '0;

   // predictor copy of registers and lamp state
   logic [11:0]  avg_flicker = 12'd20;
   logic [11:0]  avg_on = 12'd0;
   logic [11:0]  avg_off = 12'd40;
   logic [11:0]  blink_on = 12'd1;
   logic [11:0]  blink_off = 12'd1;
   logic [6:0]   inv_pct = 7'd0;
   logic [1:0]   lamp_ph = PH_FLICKER;
   logic [12:0]  frames_cnt = 13'd0;

   lamp_out_type lamp_due[$];
   int           lamp_mismatches = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  stall_pct = 0;

   stim_row_type dir_tab [NumRows] = '{
      '{1'b1, CSR_FLICKER_AVG, 12'd0,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_ON_AVG,      12'd0,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_OFF_AVG,     12'd0,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_BLINK_ON,    12'd0,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_BLINK_OFF,   12'd0,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_INVERT_PCT,  12'hFFF,   15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_UNUSED_LO,   12'hFFF,   15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_UNUSED_HI,   12'h0,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      // both weights zero: off, zero average gives one frame
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0000, 15'h0000, 15'h0000, 1'b1, 1'b0, PH_OFF},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b1, 1'b0, PH_OFF},
      // zero blink period, percent above 100 always inverts
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0000, 15'h0000, 15'h0000, 1'b1, 1'b1, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b1, 1'b1, PH_FLICKER},
      '{1'b1, CSR_ON_AVG,      12'd1,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_INVERT_PCT,  12'd0,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_BLINK_ON,    12'd2,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_BLINK_OFF,   12'd3,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0000, 15'h0000, 15'h0000, 1'b1, 1'b1, PH_ON},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b1, 1'b1, PH_ON},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h5555, 15'h2AAA, 15'h5555, 1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h2AAA, 15'h5555, 15'h2AAA, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_FLICKER_AVG, 12'd7,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_ON_AVG,      12'd3,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_OFF_AVG,     12'd3,     15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_INVERT_PCT,  12'd50,    15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h7FFF, 15'h7FFF, 15'd49,   1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0000, 15'h0000, 15'd50,   1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0001, 15'h0002, 15'h0003, 1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0000, 15'h0000, 15'h0000, 1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0000, 15'h0000, 15'd49,   1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0000, 15'h0000, 15'd50,   1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0000, 15'h0000, 15'h7FFF, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_BLINK_ON,    12'hFFF,   15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b1, CSR_BLINK_OFF,   12'hFFF,   15'h0, 15'h0, 15'h0, 1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0000, 15'h0000, 15'h0000, 1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0000, 15'h7FFF, 15'h0000, 1'b0, 1'b0, PH_FLICKER},
      // choice value equal to the on weight, sent while the on phase counts down
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0003, 15'h0000, 15'h0000, 1'b0, 1'b0, PH_FLICKER},
      '{1'b0, CSR_FLICKER_AVG, 12'd0, 15'h0003, 15'h0001, 15'h0063, 1'b0, 1'b0, PH_FLICKER}
   };

   random_lamp_flicker_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // one frame tick of the lamp: countdown/phase update first, then visibility
   function automatic lamp_out_type advance_lamp(input logic [14:0] ch, input logic [14:0] jt,
                                                 input logic [14:0] fl);
      int unsigned  span;
      int unsigned  tm;
      int           dur;
      logic [1:0]   nxt;
      lamp_out_type res;
      if (frames_cnt != 13'd0) begin
         frames_cnt = frames_cnt - 13'd1;
      end else begin
         nxt = PH_FLICKER;
         tm = 32'(avg_flicker);
         if (lamp_ph == PH_FLICKER) begin
            span = 32'(avg_on) + 32'(avg_off);
            if (span == 0) span = 1;
            if ((32'(ch) % span) < 32'(avg_on)) begin
               nxt = PH_ON;
               tm = 32'(avg_on);
            end else begin
               nxt = PH_OFF;
               tm = 32'(avg_off);
            end
         end
         dur = 0;
         if (tm > 0) dur = int'(tm) + int'(32'(jt) % tm) - int'(tm / 2);
         if (dur < 1) dur = 1;
         lamp_ph = nxt;
         frames_cnt = dur[12:0];
      end
      res.ph = lamp_ph;
      if (lamp_ph == PH_OFF) begin
         res.vis = 1'b0;
      end else if (lamp_ph == PH_FLICKER) begin
         span = 32'(blink_on) + 32'(blink_off);
         if (span == 0) span = 1;
         res.vis = ((32'(frames_cnt) % span) < 32'(blink_on));
         if (inv_pct != 0 && (32'(fl) % 100) < 32'(inv_pct)) res.vis = ~res.vis;
      end else begin
         res.vis = 1'b1;
      end
      return res;
   endfunction

   // leaves csr_wen high; the next tick lowers it
   task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
      req_tvalid <= 1'b0;
      while (lamp_due.size() != 0) @(posedge clock);
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_FLICKER_AVG: avg_flicker = val;
         CSR_ON_AVG:      avg_on = val;
         CSR_OFF_AVG:     avg_off = val;
         CSR_BLINK_ON:    blink_on = val;
         CSR_BLINK_OFF:   blink_off = val;
         CSR_INVERT_PCT:  inv_pct = val[6:0];
         default: ;
      endcase
   endtask

   task automatic send_tick(input logic [14:0] ch, input logic [14:0] jt, input logic [14:0] fl,
                            input logic typed, input lamp_out_type typed_out);
      lamp_out_type pred;
      csr_wen <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, fl, jt, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = advance_lamp(ch, jt, fl);
      lamp_due.push_back(typed ? typed_out : pred);
   endtask

   task automatic random_ticks(input int count, input bit max_jitter, input bit pause_mid);
      logic [14:0] jt;
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) begin
            req_tvalid <= 1'b0;
            while (lamp_due.size() != 0) @(posedge clock);
         end
         jt = 15'($urandom_range(32767));
         // jitter that gives the longest duration at an average of 4095
         if (max_jitter && $urandom_range(1) == 1) jt = 15'(4094 + 4095 * $urandom_range(7));
         send_tick(15'($urandom_range(32767)), jt, 15'($urandom_range(32767)), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      lamp_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (lamp_due.size() == 0) begin
            lamp_mismatches++;
            $display("%0t: unexpected item, expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = lamp_due.pop_front();
            if (rsp_tdata[0] !== want.vis) begin
               lamp_mismatches++;
               $display("%0t: lamp_visible expected %0d actual %0d", $time, want.vis,
                        rsp_tdata[0]);
            end
            if (rsp_tdata[2:1] !== want.ph) begin
               lamp_mismatches++;
               $display("%0t: lamp_phase expected %0d actual %0d", $time, want.ph,
                        rsp_tdata[2:1]);
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      lamp_out_type typed_out;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NumRows; r++) begin
         if (dir_tab[r].wr) begin
            write_reg(dir_tab[r].idx, dir_tab[r].val);
         end else begin
            typed_out.vis = dir_tab[r].vis;
            typed_out.ph = dir_tab[r].ph;
            send_tick(dir_tab[r].ch, dir_tab[r].jt, dir_tab[r].fl, dir_tab[r].typed,
                      typed_out);
         end
      end

      // short averages keep the lamp cycling through all phases
      for (int p = 0; p < 5; p++) begin
         send_idle_pct = (p == 1) ? 80 : (p == 3) ? 23 : 0;
         stall_pct = (p == 2) ? 80 : (p == 3) ? 23 : 0;
         write_reg(CSR_FLICKER_AVG, 12'($urandom_range(12)));
         write_reg(CSR_ON_AVG, 12'($urandom_range(12)));
         write_reg(CSR_OFF_AVG, 12'($urandom_range(12)));
         write_reg(CSR_BLINK_ON, 12'($urandom_range(6)));
         write_reg(CSR_BLINK_OFF, 12'($urandom_range(6)));
         write_reg(CSR_INVERT_PCT, 12'($urandom_range(100)));
         random_ticks(70, 1'b0, p == 4);
      end

      send_idle_pct = 23;
      stall_pct = 23;
      write_reg(CSR_FLICKER_AVG, 12'hFFF);
      write_reg(CSR_ON_AVG, 12'hFFF);
      write_reg(CSR_OFF_AVG, 12'hFFF);
      write_reg(CSR_BLINK_ON, 12'hFFF);
      write_reg(CSR_BLINK_OFF, 12'hFFF);
      write_reg(CSR_INVERT_PCT, 12'd100);
      random_ticks(60, 1'b1, 1'b0);

      req_tvalid <= 1'b0;
      while (lamp_due.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (lamp_mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
